[sv/sha256_pkg.sv]
// ============================================================================
// SHA-256 shared definitions
// Round constants, initial hash, round and schedule helper functions.
// ============================================================================
package sha256_pkg;

    typedef logic [31:0] t_word;

    // Entry queued from the front part to the back part.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       is_last;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } t_state;

    localparam int unsigned LenOffset = 56;

    function automatic t_word round_k(input logic [5:0] idx);
        t_word k;
        begin
            case (idx)
                6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
                6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
                6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
                6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
            endcase
            return k;
        end
    endfunction

    function automatic t_word init_hash(input logic [2:0] idx);
        t_word h;
        begin
            case (idx)
                3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
                3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
                3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
                3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
            endcase
            return h;
        end
    endfunction

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

[sv/sha256_front.sv]
// ============================================================================
// SHA-256 input queue
// Accepts stream words, drops those that carry nothing, and queues the rest.
// ============================================================================
module sha256_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  sha256_pkg::t_item    i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output sha256_pkg::t_item    o_item
);
    import sha256_pkg::*;

    // Four-entry queue.
    t_item      r_mem [4];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [2:0] r_cnt;
    logic       w_push;
    logic       w_pop;
    logic       w_useful;

    assign o_ready  = (r_cnt != 3'd4);
    assign w_useful = i_item.byte_present | i_item.is_last;
    assign w_push   = i_valid & o_ready & w_useful;
    assign w_pop    = o_valid & i_ready;
    assign o_valid  = (r_cnt != 3'd0);
    assign o_item   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 2'd1;
            if (w_pop)  r_rd <= r_rd + 2'd1;
            r_cnt <= r_cnt + {2'd0, w_push} - {2'd0, w_pop};
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 3'd4) |-> !w_push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 3'd0) |-> !w_pop) else $error("queue underflow");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4) else $error("queue count out of range");
`endif
endmodule

[sv/sha256_core.sv]
// ============================================================================
// SHA-256 block engine
// Collects bytes, pads, runs one round per cycle and emits the digest.
// ============================================================================
module sha256_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  sha256_pkg::t_item    i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [31:0]          o_word,
    output logic [2:0]           o_index,
    output logic                 o_last
);
    import sha256_pkg::*;

    t_state      r_state, n_state;
    t_word       r_blk [16];      // block as big-endian words
    logic [5:0]  r_fill;
    logic [60:0] r_count;
    t_word       r_h [8];
    t_word       r_v [8];
    t_word       r_w [16];
    logic [5:0]  r_rnd;
    logic [2:0]  r_idx;
    logic        r_final;         // block being compressed ends the message
    logic        r_pad2;          // a second (length) block still follows
    logic        w_take;
    logic        w_done_rnd;

    t_word w_wt, w_t1, w_t2, w_s0, w_s1;
    t_word w_w2, w_w15;

    assign o_ready    = (r_state == ST_IDLE);
    assign w_take     = i_valid & o_ready;
    assign w_done_rnd = (r_rnd == 6'd63);

    // Message schedule: the window is a shift line, r_w[0] is oldest.
    always_comb begin
        w_w2  = r_w[14];
        w_w15 = r_w[1];
        w_s1  = rotr(w_w2, 17) ^ rotr(w_w2, 19) ^ (w_w2 >> 10);
        w_s0  = rotr(w_w15, 7) ^ rotr(w_w15, 18) ^ (w_w15 >> 3);
        if (r_rnd < 6'd16) begin
            w_wt = r_blk[r_rnd[3:0]];
        end else begin
            w_wt = w_s1 + r_w[9] + w_s0 + r_w[0];
        end
        w_t1 = r_v[7] + (rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25))
             + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + round_k(r_rnd) + w_wt;
        w_t2 = (rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22))
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    if (i_item.is_last || (i_item.byte_present && r_fill == 6'd63)) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_LOAD:  n_state = ST_ROUND;
            ST_ROUND: if (w_done_rnd) n_state = ST_ADD;
            ST_ADD: begin
                if (r_pad2)       n_state = ST_LOAD;
                else if (r_final) n_state = ST_EMIT;
                else              n_state = ST_IDLE;
            end
            ST_EMIT:  if (i_ready && r_idx == 3'd7) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    assign o_valid = (r_state == ST_EMIT);
    assign o_word  = r_h[r_idx];
    assign o_index = r_idx;
    assign o_last  = (r_idx == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // Byte position after an optional byte on the taken item.
    logic [5:0]  w_pos;
    logic [6:0]  w_pos1;
    logic [60:0] w_cnt;
    logic [63:0] w_bits;
    logic        w_full_end;
    t_word       w_blk [16];
    always_comb begin
        w_pos      = r_fill + {5'd0, i_item.byte_present};
        w_pos1     = {1'b0, w_pos} + 7'd1;
        w_cnt      = r_count + {60'd0, i_item.byte_present};
        w_bits     = {w_cnt, 3'b000};
        w_full_end = i_item.byte_present && (r_fill == 6'd63);
    end

    // Next block contents for a taken word: the byte, then on an end mark
    // the pad byte, zeros and, if it fits, the bit length.
    always_comb begin
        for (int k = 0; k < 16; k++) w_blk[k] = r_blk[k];
        if (i_item.byte_present) begin
            w_blk[r_fill[5:2]][8*(3-r_fill[1:0]) +: 8] = i_item.data_byte;
        end
        if (i_item.is_last && !w_full_end) begin
            for (int j = 0; j < 64; j++) begin
                if (j == int'(w_pos))
                    w_blk[j/4][8*(3-(j%4)) +: 8] = 8'h80;
                else if (j > int'(w_pos))
                    w_blk[j/4][8*(3-(j%4)) +: 8] = 8'h00;
            end
            if (!(w_pos1 > 7'(LenOffset))) begin
                w_blk[14] = w_bits[63:32];
                w_blk[15] = w_bits[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_count <= '0;
            r_final <= 1'b0;
            r_pad2  <= 1'b0;
            r_rnd   <= '0;
            r_idx   <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= init_hash(3'(i));
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_take) begin
                        for (int k = 0; k < 16; k++) r_blk[k] <= w_blk[k];
                        if (i_item.byte_present) begin
                            r_fill  <= r_fill + 6'd1;
                            r_count <= w_cnt;
                        end
                        r_final <= i_item.is_last;
                        // A full block with end, or no room left for the
                        // length, needs a separate length block.
                        r_pad2  <= i_item.is_last
                                 && (w_full_end || (w_pos1 > 7'(LenOffset)));
                    end
                end
                ST_LOAD: begin
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    r_rnd <= '0;
                end
                ST_ROUND: begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= w_wt;
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + w_t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= w_t1 + w_t2;
                    r_rnd  <= r_rnd + 6'd1;
                end
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    if (r_pad2) begin
                        // Second block: zeros (0x80 first if not yet placed) and length.
                        r_pad2 <= 1'b0;
                        r_blk[0] <= (r_fill == 6'd0) ? 32'h8000_0000 : 32'h0000_0000;
                        for (int j = 1; j < 14; j++) r_blk[j] <= '0;
                        r_blk[14] <= r_count[60:29];
                        r_blk[15] <= {r_count[28:0], 3'b000};
                    end
                    r_idx <= '0;
                end
                ST_EMIT: begin
                    if (i_ready) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            for (int i = 0; i < 8; i++) r_h[i] <= init_hash(3'(i));
                            r_fill  <= '0;
                            r_count <= '0;
                            r_final <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_emit_only_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_final) else $error("digest without end mark");
    a_round_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && !w_done_rnd) |=> (r_state == ST_ROUND))
        else $error("round sequence cut short");
    a_index_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(r_idx)) else $error("index moved on stall");
`endif
endmodule

[sv/sha256_message_hasher.sv]
// ============================================================================
// SHA-256 message hasher
// Hashes a byte stream; an end mark pads the message and yields the digest.
// ============================================================================
// A byte that fills a block starts the round engine: it loads the working
// state, runs 64 rounds and adds the result into the hash. Throughput is set
// by the single round unit: the engine takes no byte while it compresses, and
// the four-entry input queue holds bytes meanwhile. An end mark adds one or two
// compressions plus eight output words. Synchronous active-low reset restores
// the initial hash and empties the input queue and block buffer.
module sha256_message_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic        s_axis_tuser,  // byte_present
    input  logic        s_axis_tlast,  // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // [31:0] digest_word, [34:32] word_index
    output logic        m_axis_tlast   // last_word
);
    import sha256_pkg::*;

    t_item      w_in_item;
    t_item      w_q_item;
    logic       w_q_valid;
    logic       w_q_ready;
    logic [31:0] w_word;
    logic [2:0]  w_index;

    // The input queue decouples byte acceptance from the round engine.
    assign w_in_item.data_byte    = s_axis_tdata;
    assign w_in_item.byte_present = s_axis_tuser;
    assign w_in_item.is_last      = s_axis_tlast;

    sha256_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (w_in_item),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_item  (w_q_item)
    );

    sha256_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .o_ready (w_q_ready),
        .i_item  (w_q_item),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_word  (w_word),
        .o_index (w_index),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, w_index, w_word};
endmodule
